### rtl/core/gbm_pkg.sv
// ----------------------------------------------------------------------------
// gbm_pkg: shared types and constants for the GBM path step
// Fixed-point constants, sequencer codes, register indexes, the 2^(i/16)
// table and the structs that pass between controller, datapath and config.
// ----------------------------------------------------------------------------
package gbm_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_DRIFT     = 3'd0;
    localparam logic [2:0] CFG_DIFFUSION = 3'd1;
    localparam logic [2:0] CFG_START     = 3'd2;
    localparam logic [2:0] CFG_STEPS     = 3'd3;
    localparam logic [2:0] CFG_ANTI      = 3'd4;

    localparam logic [31:0] START_RESET = 32'd65536;
    localparam logic [15:0] STEPS_RESET = 16'd1;

    // Fixed-point constants
    localparam logic signed [29:0] EXP_LIMIT   = 30'sd402653184; // 24.0 in Q8.24
    localparam logic [30:0]        INV_LN2_Q30 = 31'd1549082005;
    localparam logic [29:0]        LN2_Q30     = 30'd744261118;
    localparam logic [30:0]        ROOT16_Q30  = 31'd1121280436;
    localparam logic [30:0]        ONE_Q30     = 31'd1073741824;
    // ceil(2^20 / 6): floor(x / 6) == (x * RECIP6) >> 20 for x below 2^19
    localparam logic [17:0]        RECIP6      = 18'd174763;

    // Sequencer codes, one per datapath step
    localparam int unsigned ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] ST_TERM  = 4'd1;
    localparam logic [ST_W-1:0] ST_EXPO  = 4'd2;
    localparam logic [ST_W-1:0] ST_LOG2  = 4'd3;
    localparam logic [ST_W-1:0] ST_FRAC  = 4'd4;
    localparam logic [ST_W-1:0] ST_USQ   = 4'd5;
    localparam logic [ST_W-1:0] ST_UCUB  = 4'd6;
    localparam logic [ST_W-1:0] ST_DIV6  = 4'd7;
    localparam logic [ST_W-1:0] ST_POLY  = 4'd8;
    localparam logic [ST_W-1:0] ST_MANT  = 4'd9;
    localparam logic [ST_W-1:0] ST_SCALE = 4'd10;
    localparam logic [ST_W-1:0] ST_ROUND = 4'd11;

    typedef struct packed {
        logic signed [31:0] drift;
        logic [30:0]        diffusion;
        logic [31:0]        start;
        logic [15:0]        steps;
        logic               anti;
    } cfg_t;

    typedef struct packed {
        logic [ST_W-1:0] op;
        logic            capture;
        logic            finish;
    } cmd_t;

    typedef logic [30:0] pow2_tab_t [16];

    // 2^(i/16) in Q30, each entry rounded from the one before
    function automatic pow2_tab_t pow2_table();
        pow2_tab_t   tab;
        logic [63:0] acc;
        tab[0] = ONE_Q30;
        for (int i = 1; i < 16; i++) begin
            acc    = {33'd0, tab[i-1]} * {33'd0, ROOT16_Q30} + (64'd1 << 29);
            tab[i] = acc[60:30];
        end
        return tab;
    endfunction

    localparam pow2_tab_t POW2_TAB = pow2_table();

endpackage

### rtl/core/gbm_path_step.sv
// ----------------------------------------------------------------------------
// gbm_path_step: geometric Brownian motion path generator, one exact step
// price <- price * exp(drift +/- diffusion * shock) in fixed point, with
// path restart after steps_per_path steps and saturation at full scale.
//
//   channel   ports                                   beat
//   s_        s_valid s_ready s_shock                 one Q4.12 shock
//   m_        m_valid m_ready m_price m_step_index    one path value
//             m_path_last m_saturated
//   cfg_      cfg_wr_en cfg_index cfg_data            one register write
//
// Each beat runs through eleven sequencer steps that share one 33x33
// multiplier; the next beat is taken only once the sequencer is idle again.
// A finished result waits in its own register while the next beat runs;
// the last step holds only if that register is still full.
// Reset is synchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module gbm_path_step (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_shock,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_price,
    output logic [15:0] m_step_index,
    output logic        m_path_last,
    output logic        m_saturated
);

    gbm_pkg::cfg_t cfg;
    gbm_pkg::cmd_t cmd;

    gbm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    gbm_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cmd          (cmd),
        .s_shock      (s_shock),
        .m_price      (m_price),
        .m_step_index (m_step_index),
        .m_path_last  (m_path_last),
        .m_saturated  (m_saturated)
    );

endmodule

### rtl/core/gbm_cfg.sv
// ----------------------------------------------------------------------------
// gbm_cfg: configuration register bank
// Decodes the write port into the five path parameters.
// ----------------------------------------------------------------------------
module gbm_cfg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output gbm_pkg::cfg_t     cfg
);

    gbm_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.drift     <= '0;
            cfg_reg.diffusion <= '0;
            cfg_reg.start     <= gbm_pkg::START_RESET;
            cfg_reg.steps     <= gbm_pkg::STEPS_RESET;
            cfg_reg.anti      <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gbm_pkg::CFG_DRIFT:     cfg_reg.drift     <= $signed(cfg_data);
                gbm_pkg::CFG_DIFFUSION: cfg_reg.diffusion <= cfg_data[30:0];
                gbm_pkg::CFG_START:     cfg_reg.start     <= cfg_data;
                gbm_pkg::CFG_STEPS:     cfg_reg.steps     <= cfg_data[15:0];
                gbm_pkg::CFG_ANTI:      cfg_reg.anti      <= cfg_data[0];
                default: ; // unmapped index: drop the write
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/gbm_ctrl.sv
// ----------------------------------------------------------------------------
// gbm_ctrl: step sequencer and handshake control
// Walks the datapath through its sequencer steps and drives s_ready and m_valid.
// ----------------------------------------------------------------------------
module gbm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output gbm_pkg::cmd_t cmd
);

    logic [gbm_pkg::ST_W-1:0] state_reg, state_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     capture, finish;

    assign s_ready = (state_reg == gbm_pkg::ST_IDLE);
    assign capture = s_valid && s_ready;
    // the result register must be free, or emptied in this cycle
    assign finish  = (state_reg == gbm_pkg::ST_ROUND) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gbm_pkg::ST_IDLE:  if (s_valid) state_next = gbm_pkg::ST_TERM;
            gbm_pkg::ST_TERM:  state_next = gbm_pkg::ST_EXPO;
            gbm_pkg::ST_EXPO:  state_next = gbm_pkg::ST_LOG2;
            gbm_pkg::ST_LOG2:  state_next = gbm_pkg::ST_FRAC;
            gbm_pkg::ST_FRAC:  state_next = gbm_pkg::ST_USQ;
            gbm_pkg::ST_USQ:   state_next = gbm_pkg::ST_UCUB;
            gbm_pkg::ST_UCUB:  state_next = gbm_pkg::ST_DIV6;
            gbm_pkg::ST_DIV6:  state_next = gbm_pkg::ST_POLY;
            gbm_pkg::ST_POLY:  state_next = gbm_pkg::ST_MANT;
            gbm_pkg::ST_MANT:  state_next = gbm_pkg::ST_SCALE;
            gbm_pkg::ST_SCALE: state_next = gbm_pkg::ST_ROUND;
            gbm_pkg::ST_ROUND: if (finish) state_next = gbm_pkg::ST_IDLE;
            default:           state_next = gbm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        if (finish)                   out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gbm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign cmd.op      = state_reg;
    assign cmd.capture = capture;
    assign cmd.finish  = finish;

    a_capture_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        capture |=> state_reg == gbm_pkg::ST_TERM)
        else $error("accepted beat did not start the sequence");

    a_round_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gbm_pkg::ST_ROUND) && out_valid_reg && !m_ready
        |=> state_reg == gbm_pkg::ST_ROUND)
        else $error("result overwrote a beat still waiting");

    a_finish_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> out_valid_reg)
        else $error("finished step did not present a result");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gbm_pkg::ST_TERM) |-> $past(capture))
        else $error("sequence started without an accepted beat");

endmodule

### rtl/core/gbm_dp.sv
// ----------------------------------------------------------------------------
// gbm_dp: exponent, exp() and price update datapath
// One shared signed 33x33 multiplier, stepped by the controller, plus the
// path state and the result register.
// ----------------------------------------------------------------------------
module gbm_dp (
    input  logic          aclk,
    input  logic          aresetn,
    input  gbm_pkg::cfg_t cfg,
    input  gbm_pkg::cmd_t cmd,
    input  logic [15:0]   s_shock,
    output logic [31:0]   m_price,
    output logic [15:0]   m_step_index,
    output logic          m_path_last,
    output logic          m_saturated
);

    // operands captured with the beat
    logic [15:0]        mag_reg;
    logic               neg_reg;
    logic [31:0]        base_reg;

    // working registers
    logic [62:0]        prod_reg, prod_next;
    logic signed [29:0] e_reg;
    logic signed [6:0]  k_reg;
    logic [3:0]         idx_reg;
    logic [25:0]        u_reg;
    logic [21:0]        u2_reg;
    logic [30:0]        p_reg;

    // path state
    logic [31:0]        cur_price_reg;
    logic [15:0]        step_count_reg;

    // result register
    logic [31:0]        price_reg;
    logic [15:0]        step_index_reg;
    logic               last_reg;
    logic               sat_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic               mul_en;

    logic [15:0]        mag_in;
    logic [47:0]        term_sum;
    logic signed [37:0] drift_x, term_x, e_wide, lim_hi;
    logic signed [29:0] e_next;

    logic [6:0]         sh;
    logic [69:0]        rnd, wide, shifted;
    logic               sat;
    logic [31:0]        price;
    logic [15:0]        idx_step, limit;
    logic               last;

    assign mag_in = s_shock[15] ? 16'(~s_shock + 16'd1) : s_shock;

    // multiplier operand select; results feed back as slices of prod_reg
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            gbm_pkg::ST_TERM: begin
                mul_a = {2'b0, cfg.diffusion};
                mul_b = {17'b0, mag_reg};
            end
            gbm_pkg::ST_LOG2: begin
                mul_a = 33'(e_reg);
                mul_b = {2'b0, gbm_pkg::INV_LN2_Q30};
            end
            gbm_pkg::ST_FRAC: begin
                mul_a = {13'b0, prod_reg[49:30]};
                mul_b = {3'b0, gbm_pkg::LN2_Q30};
            end
            gbm_pkg::ST_USQ: begin
                mul_a = {7'b0, prod_reg[49:24]};
                mul_b = {7'b0, prod_reg[49:24]};
            end
            gbm_pkg::ST_UCUB: begin
                mul_a = {11'b0, prod_reg[51:30]};
                mul_b = {7'b0, u_reg};
            end
            gbm_pkg::ST_DIV6: begin
                mul_a = {15'b0, prod_reg[47:30]};
                mul_b = {15'b0, gbm_pkg::RECIP6};
            end
            gbm_pkg::ST_MANT: begin
                mul_a = {2'b0, gbm_pkg::POW2_TAB[idx_reg]};
                mul_b = {2'b0, p_reg};
            end
            gbm_pkg::ST_SCALE: begin
                mul_a = {1'b0, base_reg};
                mul_b = {2'b0, prod_reg[60:30]};
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign prod_next = mul_p[62:0];

    // exponent: drift plus or minus the rounded diffusion term, clamped
    always_comb begin
        term_sum = {1'b0, prod_reg[46:0]} + 48'd2048;
        drift_x  = 38'(cfg.drift);
        term_x   = $signed({2'b0, term_sum[47:12]});
        e_wide   = neg_reg ? (drift_x - term_x) : (drift_x + term_x);
        lim_hi   = 38'(gbm_pkg::EXP_LIMIT);
        if (e_wide > lim_hi)       e_next = gbm_pkg::EXP_LIMIT;
        else if (e_wide < -lim_hi) e_next = -gbm_pkg::EXP_LIMIT;
        else                       e_next = e_wide[29:0];
    end

    // scale by 2^(k-30): offset by four so a left shift of up to four fits
    always_comb begin
        sh      = 7'd34 - $unsigned(k_reg);
        rnd     = (sh > 7'd4) ? (70'd1 << (sh - 7'd1)) : '0;
        wide    = {3'b0, prod_reg, 4'b0} + rnd;
        shifted = wide >> sh;
        sat     = |shifted[69:32];
        price   = sat ? '1 : shifted[31:0];
    end

    always_comb begin
        idx_step = step_count_reg + 16'd1;
        limit    = (cfg.steps == '0) ? 16'd1 : cfg.steps;
        last     = (idx_step >= limit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg <= '0;
        end else if (cmd.finish) begin
            step_count_reg <= last ? '0 : idx_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mag_reg  <= mag_in;
            neg_reg  <= s_shock[15] ^ cfg.anti;
            base_reg <= (step_count_reg == '0) ? cfg.start : cur_price_reg;
        end
        if (mul_en) prod_reg <= prod_next;
        if (cmd.op == gbm_pkg::ST_EXPO) e_reg <= e_next;
        if (cmd.op == gbm_pkg::ST_FRAC) begin
            k_reg   <= $signed(prod_reg[60:54]);
            idx_reg <= prod_reg[53:50];
        end
        if (cmd.op == gbm_pkg::ST_USQ)  u_reg  <= prod_reg[49:24];
        if (cmd.op == gbm_pkg::ST_UCUB) u2_reg <= prod_reg[51:30];
        if (cmd.op == gbm_pkg::ST_POLY) begin
            p_reg <= gbm_pkg::ONE_Q30 + {5'b0, u_reg} + {10'b0, u2_reg[21:1]}
                     + {13'b0, prod_reg[37:20]};
        end
        if (cmd.finish) begin
            cur_price_reg  <= price;
            price_reg      <= price;
            step_index_reg <= idx_step;
            last_reg       <= last;
            sat_reg        <= sat;
        end
    end

    assign m_price      = price_reg;
    assign m_step_index = step_index_reg;
    assign m_path_last  = last_reg;
    assign m_saturated  = sat_reg;

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish && last |=> step_count_reg == '0)
        else $error("path end did not restart the step count");

endmodule
